/* sv/lvm_pkg.sv */
`timescale 1ns / 1ps
package lvm_pkg;

  localparam int FRAC_BITS_DEF = 16;
  // bits kept of each magnitude after the common normalizing shift
  localparam int NORM_MANT = 30;
  // one result bit per step of the square root
  localparam int SQ_STEPS = 32;
  localparam int CROSS_LAT = 2;
  localparam int DOT_LAT = 3;
  // rounded dot product before saturation
  localparam int DOT_W = 35;

  localparam logic [1:0] ROW_RIGHT = 2'd0;
  localparam logic [1:0] ROW_UP    = 2'd1;
  localparam logic [1:0] ROW_BACK  = 2'd2;
  localparam logic [1:0] ROW_LAST  = 2'd3;

  // magnitude, msb, shift, square, sum, root steps, numerator, quotient steps, sign
  function automatic int norm_lat(input int frac);
    return 5 + SQ_STEPS + 1 + (frac + 1) + 1;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [DOT_W-1:0] x);
    logic [31:0] res;
    if (x > $signed(DOT_W'(64'sd2147483647))) begin
      res = 32'h7fff_ffff;
    end else if (x < $signed(DOT_W'(-64'sd2147483648))) begin
      res = 32'h8000_0000;
    end else begin
      res = x[31:0];
    end
    return res;
  endfunction

endpackage

/* sv/lvm_cam_if.sv */
`timescale 1ns / 1ps
interface lvm_cam_if;
  logic        valid;
  logic        ready;
  logic [31:0] cam_pos_x;
  logic [31:0] cam_pos_y;
  logic [31:0] cam_pos_z;
  logic [31:0] look_target_x;
  logic [31:0] look_target_y;
  logic [31:0] look_target_z;
  logic [31:0] up_hint_x;
  logic [31:0] up_hint_y;
  logic [31:0] up_hint_z;

  modport source(output valid, cam_pos_x, cam_pos_y, cam_pos_z, look_target_x,
                 look_target_y, look_target_z, up_hint_x, up_hint_y, up_hint_z,
                 input ready);
  modport sink(input valid, cam_pos_x, cam_pos_y, cam_pos_z, look_target_x,
               look_target_y, look_target_z, up_hint_x, up_hint_y, up_hint_z,
               output ready);
endinterface

/* sv/lvm_row_if.sv */
`timescale 1ns / 1ps
interface lvm_row_if;
  logic        valid;
  logic        ready;
  logic [1:0]  row_index;
  logic [31:0] elem_col0;
  logic [31:0] elem_col1;
  logic [31:0] elem_col2;
  logic [31:0] elem_col3;
  logic        degenerate;
  logic        last_row;

  modport source(output valid, row_index, elem_col0, elem_col1, elem_col2, elem_col3,
                 degenerate, last_row, input ready);
  modport sink(input valid, row_index, elem_col0, elem_col1, elem_col2, elem_col3,
               degenerate, last_row, output ready);
endinterface

/* sv/lookat_view_matrix_core.sv */
`timescale 1ns / 1ps
// Look-at view matrix generator.
// camera (sink): one transfer carries a camera position, a target point and a
// world up hint, all signed fixed point with FRAC_BITS fraction bits.
// matrix (source): each camera transfer yields four row transfers in order:
// right, true up, negated forward (each with its translation in column 3)
// and the constant row 0,0,0,1. last_row marks the fourth; degenerate is set
// on all four when direction, up hint or either cross product has no length.
// The first row appears once the camera transfer has passed the input
// capture, normalizers, cross products, dot products and the output holder;
// the next three follow one per cycle while matrix.ready is high. A camera
// item can enter every cycle while the output holder is empty or draining,
// but each finished matrix holds the pipeline until its four rows are out. The
// depth comes from three normalizers in series, each with a 32-step square root and a FRAC_BITS+1 step divider.
// Reset clears the valid bits and the row counter; no rows are pending after.
// A stall on matrix freezes the whole pipeline in place: nothing is dropped
// or repeated, and camera.ready falls until the held matrix drains.
module lookat_view_matrix_core import lvm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lvm_cam_if.sink    camera,
  lvm_row_if.source  matrix
);

  localparam int UW    = FRAC_BITS + 2;
  localparam int CW    = 2 * FRAC_BITS + 3;
  localparam int NL    = norm_lat(FRAC_BITS);
  localparam int SEG   = NL + CROSS_LAT;
  localparam int P_LAT = 3 * NL + 2 * CROSS_LAT;
  localparam int V_LAT = P_LAT + DOT_LAT;

  logic       en;
  logic       hold_v;
  logic [1:0] row_cnt;

  // advance everything whenever the output holder is empty or drains now
  assign en = !hold_v || (matrix.ready && row_cnt == ROW_LAST);
  assign camera.ready = en;

  // input capture; direction is formed at 33 bits so it never wraps
  logic              c0_v;
  logic [2:0][31:0]  c0_p;
  logic [2:0][32:0]  c0_d;
  logic [2:0][31:0]  c0_u;

  always_ff @(posedge clk) begin
    if (rst) begin
      c0_v <= 1'b0;
    end else if (en) begin
      c0_v <= camera.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0_p[0] <= camera.cam_pos_x;
      c0_p[1] <= camera.cam_pos_y;
      c0_p[2] <= camera.cam_pos_z;
      c0_d[0] <= 33'($signed(camera.look_target_x)) - 33'($signed(camera.cam_pos_x));
      c0_d[1] <= 33'($signed(camera.look_target_y)) - 33'($signed(camera.cam_pos_y));
      c0_d[2] <= 33'($signed(camera.look_target_z)) - 33'($signed(camera.cam_pos_z));
      c0_u[0] <= camera.up_hint_x;
      c0_u[1] <= camera.up_hint_y;
      c0_u[2] <= camera.up_hint_z;
    end
  end

  // forward and up hint, normalized side by side
  logic [2:0][UW-1:0] f_n;
  logic [2:0][UW-1:0] u_n;
  logic               f_ok;
  logic               u_ok;

  lvm_norm3 #(.FRAC_BITS(FRAC_BITS), .IW(33)) u_norm_f (
    .clk(clk), .en(en), .v(c0_d), .o(f_n), .ok(f_ok)
  );

  lvm_norm3 #(.FRAC_BITS(FRAC_BITS), .IW(32)) u_norm_u (
    .clk(clk), .en(en), .v(c0_u), .o(u_n), .ok(u_ok)
  );

  // right = normalize(f x u)
  logic [2:0][CW-1:0] rc;
  logic [2:0][UW-1:0] r_n;
  logic [2:0][UW-1:0] f_d1;
  logic               r_ok;
  logic               ok_a;

  lvm_cross3 #(.FRAC_BITS(FRAC_BITS)) u_cross_r (
    .clk(clk), .en(en), .a(f_n), .b(u_n), .o(rc)
  );

  lvm_norm3 #(.FRAC_BITS(FRAC_BITS), .IW(CW)) u_norm_r (
    .clk(clk), .en(en), .v(rc), .o(r_n), .ok(r_ok)
  );

  lvm_delay #(.W(3*UW), .N(SEG)) u_dly_f1 (
    .clk(clk), .rst(rst), .en(en), .din(f_n), .dout(f_d1)
  );

  lvm_delay #(.W(1), .N(SEG)) u_dly_ok1 (
    .clk(clk), .rst(rst), .en(en), .din(f_ok & u_ok), .dout(ok_a)
  );

  // true up = normalize(r x f)
  logic [2:0][CW-1:0] tc;
  logic [2:0][UW-1:0] t_n;
  logic [2:0][UW-1:0] r_d;
  logic [2:0][UW-1:0] f_d2;
  logic               t_ok;
  logic               ok_b;

  lvm_cross3 #(.FRAC_BITS(FRAC_BITS)) u_cross_t (
    .clk(clk), .en(en), .a(r_n), .b(f_d1), .o(tc)
  );

  lvm_norm3 #(.FRAC_BITS(FRAC_BITS), .IW(CW)) u_norm_t (
    .clk(clk), .en(en), .v(tc), .o(t_n), .ok(t_ok)
  );

  lvm_delay #(.W(3*UW), .N(SEG)) u_dly_r (
    .clk(clk), .rst(rst), .en(en), .din(r_n), .dout(r_d)
  );

  lvm_delay #(.W(3*UW), .N(SEG)) u_dly_f2 (
    .clk(clk), .rst(rst), .en(en), .din(f_d1), .dout(f_d2)
  );

  lvm_delay #(.W(1), .N(SEG)) u_dly_ok2 (
    .clk(clk), .rst(rst), .en(en), .din(ok_a & r_ok), .dout(ok_b)
  );

  // translations: dot products against the position
  logic [2:0][31:0]   p_d;
  logic [DOT_W-1:0]   dr;
  logic [DOT_W-1:0]   dt;
  logic [DOT_W-1:0]   df;

  lvm_delay #(.W(96), .N(P_LAT)) u_dly_p (
    .clk(clk), .rst(rst), .en(en), .din(c0_p), .dout(p_d)
  );

  lvm_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_r (
    .clk(clk), .en(en), .a(r_d), .p(p_d), .d(dr)
  );

  lvm_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_t (
    .clk(clk), .en(en), .a(t_n), .p(p_d), .d(dt)
  );

  lvm_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_f (
    .clk(clk), .en(en), .a(f_d2), .p(p_d), .d(df)
  );

  // keep the basis vectors aligned with the dot products
  logic [2:0][UW-1:0] r_e;
  logic [2:0][UW-1:0] t_e;
  logic [2:0][UW-1:0] f_e;
  logic               ok_e;
  logic               pv;

  lvm_delay #(.W(3*UW), .N(DOT_LAT)) u_dly_re (
    .clk(clk), .rst(rst), .en(en), .din(r_d), .dout(r_e)
  );

  lvm_delay #(.W(3*UW), .N(DOT_LAT)) u_dly_te (
    .clk(clk), .rst(rst), .en(en), .din(t_n), .dout(t_e)
  );

  lvm_delay #(.W(3*UW), .N(DOT_LAT)) u_dly_fe (
    .clk(clk), .rst(rst), .en(en), .din(f_d2), .dout(f_e)
  );

  lvm_delay #(.W(1), .N(DOT_LAT)) u_dly_oke (
    .clk(clk), .rst(rst), .en(en), .din(ok_b & t_ok), .dout(ok_e)
  );

  // valid bit rides alongside the whole datapath
  lvm_delay #(.W(1), .N(V_LAT)) u_dly_v (
    .clk(clk), .rst(rst), .en(en), .din(c0_v), .dout(pv)
  );

  // output holder: one finished matrix, sent out a row per transfer
  logic [2:0][31:0] h_r;
  logic [2:0][31:0] h_t;
  logic [2:0][31:0] h_f;
  logic [2:0][31:0] h_c3;
  logic             h_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v  <= 1'b0;
      row_cnt <= ROW_RIGHT;
    end else if (en) begin
      hold_v  <= pv;
      row_cnt <= ROW_RIGHT;
    end else if (hold_v && matrix.ready) begin
      row_cnt <= row_cnt + 2'd1;
    end
  end

  // zero the first three rows when the basis could not be built
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        h_r[i] <= ok_e ? 32'($signed(r_e[i])) : '0;
        h_t[i] <= ok_e ? 32'($signed(t_e[i])) : '0;
        h_f[i] <= ok_e ? 32'(-$signed(f_e[i])) : '0;
      end
      h_c3[0] <= ok_e ? sat32(DOT_W'(-$signed(dr))) : '0;
      h_c3[1] <= ok_e ? sat32(DOT_W'(-$signed(dt))) : '0;
      h_c3[2] <= ok_e ? sat32(df) : '0;
      h_deg   <= !ok_e;
    end
  end

  always_comb begin
    case (row_cnt)
      ROW_RIGHT: begin
        matrix.elem_col0 = h_r[0];
        matrix.elem_col1 = h_r[1];
        matrix.elem_col2 = h_r[2];
        matrix.elem_col3 = h_c3[0];
      end
      ROW_UP: begin
        matrix.elem_col0 = h_t[0];
        matrix.elem_col1 = h_t[1];
        matrix.elem_col2 = h_t[2];
        matrix.elem_col3 = h_c3[1];
      end
      ROW_BACK: begin
        matrix.elem_col0 = h_f[0];
        matrix.elem_col1 = h_f[1];
        matrix.elem_col2 = h_f[2];
        matrix.elem_col3 = h_c3[2];
      end
      default: begin
        matrix.elem_col0 = '0;
        matrix.elem_col1 = '0;
        matrix.elem_col2 = '0;
        matrix.elem_col3 = 32'd1 << FRAC_BITS;
      end
    endcase
  end

  assign matrix.valid      = hold_v;
  assign matrix.row_index  = row_cnt;
  assign matrix.degenerate = h_deg;
  assign matrix.last_row   = (row_cnt == ROW_LAST);

endmodule

/* sv/lvm_delay.sv */
`timescale 1ns / 1ps
module lvm_delay import lvm_pkg::*; #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] taps [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N; k++) taps[k] <= '0;
    end else if (en) begin
      taps[0] <= din;
      for (int k = 1; k < N; k++) taps[k] <= taps[k-1];
    end
  end

  assign dout = taps[N-1];

endmodule

/* sv/lvm_norm3.sv */
`timescale 1ns / 1ps
module lvm_norm3 import lvm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int IW = 33
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [2:0][IW-1:0]         v,
  output logic [2:0][FRAC_BITS+1:0]  o,
  output logic                       ok
);

  localparam int MW = $clog2(IW);
  localparam int UW = FRAC_BITS + 2;
  localparam int QW = FRAC_BITS + 1;
  localparam int NW = NORM_MANT + 1 + FRAC_BITS;
  localparam int DS = FRAC_BITS + 1;

  // magnitudes and largest one
  logic [2:0][IW-1:0] mag;
  logic [IW-1:0]      top;
  logic [2:0][IW-1:0] s1_m;
  logic [2:0]         s1_sg;
  logic [IW-1:0]      s1_top;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i][IW-1] ? IW'(-v[i]) : v[i];
    end
    top = (mag[0] > mag[1]) ? mag[0] : mag[1];
    top = (mag[2] > top) ? mag[2] : top;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_m   <= mag;
      s1_top <= top;
      for (int i = 0; i < 3; i++) s1_sg[i] <= v[i][IW-1];
    end
  end

  // leading one of the largest magnitude
  logic [MW-1:0]      msb;
  logic [2:0][IW-1:0] s2_m;
  logic [2:0]         s2_sg;
  logic               s2_nz;
  logic [MW-1:0]      s2_msb;

  always_comb begin
    msb = '0;
    for (int b = 0; b < IW; b++) begin
      if (s1_top[b]) msb = MW'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_m   <= s1_m;
      s2_sg  <= s1_sg;
      s2_nz  <= |s1_top;
      s2_msb <= msb;
    end
  end

  // shift all three so the largest lands in [2^29, 2^30)
  logic [2:0][IW+NORM_MANT-1:0] ext;
  logic [2:0][NORM_MANT-1:0]    s3_mn;
  logic [2:0]                   s3_sg;
  logic                         s3_nz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext[i] = {s2_m[i], {NORM_MANT{1'b0}}} >> (int'(s2_msb) + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s3_mn[i] <= ext[i][NORM_MANT-1:0];
      s3_sg <= s2_sg;
      s3_nz <= s2_nz;
    end
  end

  // squares
  logic [2:0][2*NORM_MANT-1:0] s4_sq;
  logic [2:0][NORM_MANT-1:0]   s4_mn;
  logic [2:0]                  s4_sg;
  logic                        s4_nz;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s4_sq[i] <= (2*NORM_MANT)'(s3_mn[i]) * (2*NORM_MANT)'(s3_mn[i]);
      end
      s4_mn <= s3_mn;
      s4_sg <= s3_sg;
      s4_nz <= s3_nz;
    end
  end

  // integer square root, one result bit per stage
  logic [63:0]                 sq_n [SQ_STEPS+1];
  logic [63:0]                 sq_r [SQ_STEPS+1];
  logic [63:0]                 sq_t [SQ_STEPS];
  logic [63:0]                 sq_n_next [SQ_STEPS];
  logic [63:0]                 sq_r_next [SQ_STEPS];
  logic [2:0][NORM_MANT-1:0]   sd_mn [SQ_STEPS+1];
  logic [2:0]                  sd_sg [SQ_STEPS+1];
  logic                        sd_nz [SQ_STEPS+1];

  always_comb begin
    for (int k = 0; k < SQ_STEPS; k++) begin
      sq_t[k] = sq_r[k] + (64'd1 << (62 - 2*k));
      if (sq_n[k] >= sq_t[k]) begin
        sq_n_next[k] = sq_n[k] - sq_t[k];
        sq_r_next[k] = (sq_r[k] >> 1) + (64'd1 << (62 - 2*k));
      end else begin
        sq_n_next[k] = sq_n[k];
        sq_r_next[k] = sq_r[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_n[0]  <= 64'(s4_sq[0]) + 64'(s4_sq[1]) + 64'(s4_sq[2]);
      sq_r[0]  <= '0;
      sd_mn[0] <= s4_mn;
      sd_sg[0] <= s4_sg;
      sd_nz[0] <= s4_nz;
      for (int k = 0; k < SQ_STEPS; k++) begin
        sq_n[k+1]  <= sq_n_next[k];
        sq_r[k+1]  <= sq_r_next[k];
        sd_mn[k+1] <= sd_mn[k];
        sd_sg[k+1] <= sd_sg[k];
        sd_nz[k+1] <= sd_nz[k];
      end
    end
  end

  // rounded quotient, one bit per stage
  logic [NORM_MANT:0]    len;
  logic [2:0][NW-1:0]    dv_rem [DS+1];
  logic [2:0][QW-1:0]    dv_q   [DS+1];
  logic [NORM_MANT:0]    dv_l   [DS+1];
  logic [2:0]            dv_sg  [DS+1];
  logic                  dv_nz  [DS+1];
  logic [NW-1:0]         dv_d   [DS];
  logic [2:0][NW-1:0]    rem_next [DS];
  logic [2:0][QW-1:0]    q_next   [DS];

  assign len = sq_r[SQ_STEPS][NORM_MANT:0];

  always_comb begin
    for (int j = 0; j < DS; j++) begin
      dv_d[j] = NW'(dv_l[j]) << (FRAC_BITS - j);
      for (int i = 0; i < 3; i++) begin
        if (dv_rem[j][i] >= dv_d[j]) begin
          rem_next[j][i] = dv_rem[j][i] - dv_d[j];
          q_next[j][i]   = dv_q[j][i] | (QW'(1) << (FRAC_BITS - j));
        end else begin
          rem_next[j][i] = dv_rem[j][i];
          q_next[j][i]   = dv_q[j][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= (NW'(sd_mn[SQ_STEPS][i]) << FRAC_BITS) + NW'(len >> 1);
      end
      dv_q[0]  <= '0;
      dv_l[0]  <= len;
      dv_sg[0] <= sd_sg[SQ_STEPS];
      dv_nz[0] <= sd_nz[SQ_STEPS];
      for (int j = 0; j < DS; j++) begin
        dv_rem[j+1] <= rem_next[j];
        dv_q[j+1]   <= q_next[j];
        dv_l[j+1]   <= dv_l[j];
        dv_sg[j+1]  <= dv_sg[j];
        dv_nz[j+1]  <= dv_nz[j];
      end
    end
  end

  // apply sign, zero the vector when it had no length
  logic [2:0][UW-1:0] qz;

  always_comb begin
    for (int i = 0; i < 3; i++) qz[i] = UW'(dv_q[DS][i]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (!dv_nz[DS]) begin
          o[i] <= '0;
        end else begin
          o[i] <= dv_sg[DS][i] ? UW'(-qz[i]) : qz[i];
        end
      end
      ok <= dv_nz[DS];
    end
  end

endmodule

/* sv/lvm_cross3.sv */
`timescale 1ns / 1ps
module lvm_cross3 import lvm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [2:0][FRAC_BITS+1:0]     a,
  input  logic [2:0][FRAC_BITS+1:0]     b,
  output logic [2:0][2*FRAC_BITS+2:0]   o
);

  localparam int UW = FRAC_BITS + 2;
  localparam int PW = 2 * UW;
  localparam int CW = 2 * FRAC_BITS + 3;

  logic [5:0][PW-1:0] pr;

  always_ff @(posedge clk) begin
    if (en) begin
      pr[0] <= PW'($signed(a[1]) * $signed(b[2]));
      pr[1] <= PW'($signed(a[2]) * $signed(b[1]));
      pr[2] <= PW'($signed(a[2]) * $signed(b[0]));
      pr[3] <= PW'($signed(a[0]) * $signed(b[2]));
      pr[4] <= PW'($signed(a[0]) * $signed(b[1]));
      pr[5] <= PW'($signed(a[1]) * $signed(b[0]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        o[i] <= CW'($signed(pr[2*i]) - $signed(pr[2*i+1]));
      end
    end
  end

endmodule

/* sv/lvm_dot.sv */
`timescale 1ns / 1ps
module lvm_dot import lvm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [2:0][FRAC_BITS+1:0]  a,
  input  logic [2:0][31:0]           p,
  output logic [DOT_W-1:0]           d
);

  localparam int UW = FRAC_BITS + 2;
  localparam int PW = UW + 32;
  localparam int SW = PW + 2;

  logic [2:0][PW-1:0] pr;
  logic [SW-1:0]      s;
  logic [SW-1:0]      mag;
  logic [SW-1:0]      q;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) pr[i] <= PW'($signed(a[i]) * $signed(p[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s <= SW'($signed(pr[0])) + SW'($signed(pr[1])) + SW'($signed(pr[2]));
    end
  end

  // round half away from zero
  always_comb begin
    mag = s[SW-1] ? SW'(-s) : s;
    q   = (mag + (SW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d <= s[SW-1] ? DOT_W'(-q) : DOT_W'(q);
    end
  end

endmodule

/* tb/lvm_matrix_checker.sv */
`timescale 1ns / 1ps
module lvm_matrix_checker import lvm_pkg::*; (
  input  logic clk,
  input  logic rst,
  lvm_cam_if   cam,
  lvm_row_if   mat,
  output int   errors,
  output int   pending
);

  localparam int FB = FRAC_BITS_DEF;

  typedef longint vec3_t [3];

  typedef struct {
    logic [1:0]  idx;
    logic [31:0] c0;
    logic [31:0] c1;
    logic [31:0] c2;
    logic [31:0] c3;
    logic        degen;
    logic        last;
  } view_row_t;

  view_row_t rows_due[$];

  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit unit_vec(input vec3_t v, output vec3_t o);
    longint unsigned m [3];
    longint unsigned top;
    longint unsigned sum;
    longint unsigned len;
    longint unsigned q;
    int rs;
    int ls;
    top = 0;
    sum = 0;
    rs = 0;
    ls = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[i] > top) top = m[i];
    end
    if (top == 0) begin
      o = '{0, 0, 0};
      return 1'b0;
    end
    while (top >= (64'd1 << 30)) begin
      top = top >> 1;
      rs++;
    end
    while (top < (64'd1 << 29)) begin
      top = top << 1;
      ls++;
    end
    for (int i = 0; i < 3; i++) begin
      m[i] = (m[i] >> rs) << ls;
      sum += m[i] * m[i];
    end
    len = root_floor(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FB) + len / 2) / len;
      o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic vec3_t cross_of(input vec3_t a, input vec3_t b);
    vec3_t o;
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
    return o;
  endfunction

  // exact dot, rounded half away from zero back to FB fraction bits
  function automatic longint dot_round(input vec3_t a, input vec3_t p);
    longint s;
    longint unsigned q;
    s = a[0] * p[0] + a[1] * p[1] + a[2] * p[2];
    q = ((s < 0 ? -s : s) + (64'd1 << (FB - 1))) >> FB;
    return s < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [31:0] clamp32(input longint x);
    if (x > 64'sd2147483647) return 32'h7fff_ffff;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  task automatic predict_matrix;
    vec3_t p, d, uh, f, u, r, t, rc, tc;
    bit ok;
    bit degen;
    view_row_t row;
    p  = '{longint'($signed(cam.cam_pos_x)), longint'($signed(cam.cam_pos_y)),
           longint'($signed(cam.cam_pos_z))};
    d  = '{longint'($signed(cam.look_target_x)) - p[0],
           longint'($signed(cam.look_target_y)) - p[1],
           longint'($signed(cam.look_target_z)) - p[2]};
    uh = '{longint'($signed(cam.up_hint_x)), longint'($signed(cam.up_hint_y)),
           longint'($signed(cam.up_hint_z))};
    ok = unit_vec(d, f);
    ok = unit_vec(uh, u) && ok;
    rc = cross_of(f, u);
    ok = unit_vec(rc, r) && ok;
    tc = cross_of(r, f);
    ok = unit_vec(tc, t) && ok;
    if (!ok) begin
      f = '{0, 0, 0};
      r = '{0, 0, 0};
      t = '{0, 0, 0};
    end
    degen = !ok;
    row = '{ROW_RIGHT, r[0][31:0], r[1][31:0], r[2][31:0], clamp32(-dot_round(r, p)),
            degen, 1'b0};
    rows_due.push_back(row);
    row = '{ROW_UP, t[0][31:0], t[1][31:0], t[2][31:0], clamp32(-dot_round(t, p)),
            degen, 1'b0};
    rows_due.push_back(row);
    row = '{ROW_BACK, 32'(-f[0]), 32'(-f[1]), 32'(-f[2]), clamp32(dot_round(f, p)),
            degen, 1'b0};
    rows_due.push_back(row);
    row = '{ROW_LAST, 32'd0, 32'd0, 32'd0, 32'd1 << FB, degen, 1'b1};
    rows_due.push_back(row);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    view_row_t want;
    if (!rst) begin
      if (mat.valid && mat.ready) begin
        if (rows_due.size() == 0) begin
          $error("matrix row transfer with nothing outstanding");
          errors++;
        end else begin
          want = rows_due.pop_front();
          check_field("row_index", 32'(want.idx), 32'(mat.row_index));
          check_field("elem_col0", want.c0, mat.elem_col0);
          check_field("elem_col1", want.c1, mat.elem_col1);
          check_field("elem_col2", want.c2, mat.elem_col2);
          check_field("elem_col3", want.c3, mat.elem_col3);
          check_field("degenerate", 32'(want.degen), 32'(mat.degenerate));
          check_field("last_row", 32'(want.last), 32'(mat.last_row));
        end
      end
      if (cam.valid && cam.ready) predict_matrix();
    end
    pending = rows_due.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
  import lvm_pkg::*;

  // covers the wait from a camera transfer to its first row at 16 fraction bits
  localparam int DRAIN_CYCLES = 3 * FRAC_BITS_DEF + 128 + 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 215;
  localparam int ONE          = 1 << FRAC_BITS_DEF;

  typedef struct {
    logic [31:0] px, py, pz;
    logic [31:0] tx, ty, tz;
    logic [31:0] ux, uy, uz;
  } cam_item_t;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   cycles;

  // idle odds out of a hundred, set per phase by the stimulus
  int   send_idle;
  int   recv_idle;
  // long receiver hold-off, requested once by the stimulus
  bit   hold_req;
  bit   hold_done;
  int   hold_left;

  lvm_cam_if camera ();
  lvm_row_if matrix ();

  lookat_view_matrix_core u_top (
    .clk    (clk),
    .rst    (rst),
    .camera (camera.sink),
    .matrix (matrix.source)
  );

  lvm_matrix_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .cam     (camera),
    .mat     (matrix),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Watchdog: a hung handshake must not run forever.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold so the pipeline
  // fills and camera.ready must drop.
  always @(posedge clk) begin
    if (rst) begin
      matrix.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 700;
      matrix.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      matrix.ready <= 1'b0;
    end else begin
      matrix.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Hold the item until a transfer; ready is stable in the low half of
  // the clock, so sample it there to learn whether the next edge transfers.
  task automatic send_camera(input cam_item_t it);
    bit took;
    while ($urandom_range(99) < send_idle) begin
      camera.valid <= 1'b0;
      @(posedge clk);
    end
    camera.valid         <= 1'b1;
    camera.cam_pos_x     <= it.px;
    camera.cam_pos_y     <= it.py;
    camera.cam_pos_z     <= it.pz;
    camera.look_target_x <= it.tx;
    camera.look_target_y <= it.ty;
    camera.look_target_z <= it.tz;
    camera.up_hint_x     <= it.ux;
    camera.up_hint_y     <= it.uy;
    camera.up_hint_z     <= it.uz;
    do begin
      @(negedge clk);
      took = camera.ready;
      @(posedge clk);
    end while (!took);
  endtask

  function automatic logic [31:0] near_val(input int span);
    return 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic [31:0] any_val();
    case ($urandom_range(5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed cameras with random content; some wide-open noise,
  // some up hints parallel to the view, some target on the camera.
  function automatic cam_item_t random_camera();
    cam_item_t it;
    logic [31:0] dx, dy, dz;
    int k;
    case ($urandom_range(9))
      0, 1: begin
        it = '{any_val(), any_val(), any_val(), any_val(), any_val(), any_val(),
               any_val(), any_val(), any_val()};
      end
      2: begin
        dx = near_val(1 << 20);
        dy = near_val(1 << 20);
        dz = near_val(1 << 20);
        k = $urandom_range(1, 3);
        it.px = near_val(1 << 24);
        it.py = near_val(1 << 24);
        it.pz = near_val(1 << 24);
        it = '{it.px, it.py, it.pz, it.px + dx, it.py + dy, it.pz + dz,
               dx * k, dy * k, dz * k};
      end
      3: begin
        it.px = any_val();
        it.py = any_val();
        it.pz = any_val();
        it = '{it.px, it.py, it.pz, it.px, it.py, it.pz,
               near_val(ONE), near_val(ONE), near_val(ONE)};
      end
      default: begin
        it = '{near_val(1 << 26), near_val(1 << 26), near_val(1 << 26),
               near_val(1 << 26), near_val(1 << 26), near_val(1 << 26),
               near_val(ONE), near_val(ONE), near_val(ONE)};
      end
    endcase
    return it;
  endfunction

  initial begin
    cam_item_t directed [$];
    hold_req      = 1'b0;
    send_idle     = 8;
    recv_idle     = 47;
    rst           = 1'b1;
    camera.valid  = 1'b0;
    camera.cam_pos_x = '0;
    camera.cam_pos_y = '0;
    camera.cam_pos_z = '0;
    camera.look_target_x = '0;
    camera.look_target_y = '0;
    camera.look_target_z = '0;
    camera.up_hint_x = '0;
    camera.up_hint_y = '0;
    camera.up_hint_z = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // plain camera looking down -z with +y up
    directed.push_back('{0, 0, 0, 0, 0, -ONE, 0, ONE, 0});
    // off-axis camera
    directed.push_back('{3 * ONE, 2 * ONE, 5 * ONE, -ONE, 0, 0, 0, ONE, 0});
    // target on the camera: no direction
    directed.push_back('{ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE, 0});
    // zero up hint
    directed.push_back('{0, 0, 0, ONE, ONE, 0, 0, 0, 0});
    // up hint along the view direction, then against it
    directed.push_back('{0, 0, 0, 0, 5 * ONE, 0, 0, ONE, 0});
    directed.push_back('{ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, -ONE, -ONE, -ONE});
    // full-range difference: widest position, opposite target
    directed.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                         32'h8000_0000, 32'h7fff_ffff, 0});
    directed.push_back('{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                         32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                         32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000});
    // far cameras so the back-row translation saturates
    directed.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                         0, 0, 0, 0, ONE, 0});
    directed.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         0, 0, 0, ONE, 0, 0});
    // smallest step direction and tiny up hint
    directed.push_back('{0, 0, 0, 1, 0, 0, 0, 0, 1});
    directed.push_back('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                         0, 32'hffff_ffff, 0, 32'hffff_ffff, 0, 0});
    foreach (directed[i]) send_camera(directed[i]);

    // Three idle phases; the long receiver hold lands in the middle one.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle = 47;
        recv_idle = 8;
      end
      if (n == RANDOM_ITEMS / 2) hold_req = 1'b1;
      if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      send_camera(random_camera());
    end
    camera.valid <= 1'b0;

    // drain everything outstanding, then give stray rows a chance to show
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/lvm_pkg.sv
sv/lvm_cam_if.sv
sv/lvm_row_if.sv
sv/lvm_delay.sv
sv/lvm_norm3.sv
sv/lvm_cross3.sv
sv/lvm_dot.sv
sv/lookat_view_matrix_core.sv
tb/lvm_matrix_checker.sv
tb/tb.sv
